// File: sv/assert_macros.svh
// Assertion helpers; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FCM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FCM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fcm_pkg.sv
`timescale 1ns / 1ps
package fcm_pkg;

	localparam int FCM_NUM_BLOCKS = 1024;
	localparam int ACT_W = 3;
	localparam int BLK_W = 10;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam int STAT_W = 2;
	// Command queue depth, a power of two.
	localparam int FCM_Q_DEPTH = 2;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
	localparam logic [ACT_W-1:0] ACT_EXTEND = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FREE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;
	localparam logic [STAT_W-1:0] STAT_LONG = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [BLK_W-1:0] start_block;
	} fcm_in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0] block_index;
		logic [LEN_W-1:0] chain_length;
		logic at_end;
	} fcm_out_t;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_EXTEND,
		OP_FREE,
		OP_LOCATE,
		OP_READ,
		OP_BAD
	} fcm_op_t;

	typedef struct packed {
		fcm_op_t op;
		logic [BLK_W-1:0] block;
	} fcm_cmd_t;

	typedef struct packed {
		logic clearing;
		logic done;
	} fcm_eng_stat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_SEARCH,
		S_LINK,
		S_FREE,
		S_READ
	} fcm_state_t;

endpackage

// File: sv/fcm_front.sv
`timescale 1ns / 1ps
module fcm_front #(
	parameter int NUM_BLOCKS = fcm_pkg::FCM_NUM_BLOCKS
) (
	input logic req_valid,
	output logic req_stall,
	input fcm_pkg::fcm_in_t req,
	input logic clearing,
	input logic q_full,
	output logic q_push,
	output fcm_pkg::fcm_cmd_t q_cmd
);
	import fcm_pkg::*;

	logic in_rng;
	logic chain_ok;

	assign req_stall = clearing || q_full;
	assign q_push = req_valid && !req_stall;

	assign in_rng = (32'(req.start_block) < 32'(NUM_BLOCKS));
	// Block 0 is reserved and never heads a chain.
	assign chain_ok = in_rng && (req.start_block != '0);

	always_comb begin
		q_cmd.block = req.start_block;
		case (req.action)
			ACT_ALLOC: q_cmd.op = OP_ALLOC;
			ACT_EXTEND: q_cmd.op = chain_ok ? OP_EXTEND : OP_BAD;
			ACT_FREE: q_cmd.op = chain_ok ? OP_FREE : OP_BAD;
			ACT_LOCATE: q_cmd.op = chain_ok ? OP_LOCATE : OP_BAD;
			ACT_READ: q_cmd.op = in_rng ? OP_READ : OP_BAD;
			default: q_cmd.op = OP_BAD;
		endcase
	end

endmodule

// File: sv/fcm_queue.sv
`timescale 1ns / 1ps
module fcm_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fcm_pkg::fcm_cmd_t push_cmd,
	output logic full,
	output logic valid,
	output fcm_pkg::fcm_cmd_t head,
	input logic pop
);
	import fcm_pkg::*;

	localparam int QPW = (FCM_Q_DEPTH > 1) ? $clog2(FCM_Q_DEPTH) : 1;
	localparam int QCW = $clog2(FCM_Q_DEPTH + 1);
	localparam logic [QCW-1:0] Q_FULL = QCW'(FCM_Q_DEPTH);

	fcm_cmd_t slot_q [FCM_Q_DEPTH];
	logic [QPW-1:0] wp_q;
	logic [QPW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;

	assign full = (cnt_q == Q_FULL);
	assign valid = (cnt_q != '0);
	assign head = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

endmodule

// File: sv/fcm_engine.sv
`timescale 1ns / 1ps
module fcm_engine #(
	parameter int NUM_BLOCKS = fcm_pkg::FCM_NUM_BLOCKS
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input fcm_pkg::fcm_cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output fcm_pkg::fcm_out_t rsp,
	output fcm_pkg::fcm_eng_stat_t stat
);
	import fcm_pkg::*;

	localparam int ABW = $clog2(NUM_BLOCKS);
	localparam int NW = $clog2(NUM_BLOCKS + 1);
	localparam int SW = ABW + 1;
	// Entry: busy, has successor, successor index.
	localparam int EW = ABW + 2;
	localparam logic [ABW-1:0] LAST_BLK = ABW'(NUM_BLOCKS - 1);
	localparam logic [NW-1:0] N_MAX = NW'(NUM_BLOCKS);
	localparam logic [SW-1:0] SCAN_END = SW'(NUM_BLOCKS);

	logic [EW-1:0] fat_q [NUM_BLOCKS];
	logic [EW-1:0] rd_q;

	fcm_state_t state_q, state_d;
	logic [ABW-1:0] clr_q, clr_d;
	fcm_op_t op_q, op_d;
	logic [ABW-1:0] start_q, start_d;
	logic [ABW-1:0] cur_q, cur_d;
	logic [NW-1:0] n_q, n_d;
	logic first_q, first_d;
	logic [SW-1:0] scan_q, scan_d;
	logic chk_q, chk_d;
	logic [ABW-1:0] chk_addr_q, chk_addr_d;
	logic [ABW-1:0] fb_q, fb_d;
	logic tail_busy_q, tail_busy_d;
	logic out_valid_q;
	fcm_out_t out_q;

	logic [ABW-1:0] ra;
	logic we;
	logic [ABW-1:0] wa;
	logic [EW-1:0] wd;
	logic res_load;
	fcm_out_t res;
	logic [ABW-1:0] cmd_blk;
	logic issue;

	logic rd_busy;
	logic rd_next;
	logic [ABW-1:0] rd_link;

	assign rd_busy = rd_q[EW-1];
	assign rd_next = rd_q[EW-2];
	assign rd_link = rd_q[ABW-1:0];
	assign cmd_blk = ABW'(cmd.block);
	assign issue = (scan_q < SCAN_END);

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;
	assign stat.clearing = (state_q == S_CLEAR);
	assign stat.done = res_load;

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		op_d = op_q;
		start_d = start_q;
		cur_d = cur_q;
		n_d = n_q;
		first_d = first_q;
		scan_d = scan_q;
		chk_d = chk_q;
		chk_addr_d = chk_addr_q;
		fb_d = fb_q;
		tail_busy_d = tail_busy_q;
		ra = cur_q;
		we = 1'b0;
		wa = cur_q;
		wd = '0;
		res_load = 1'b0;
		res = '0;
		cmd_pop = 1'b0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = {(clr_q == '0), 1'b0, {ABW{1'b0}}};
				clr_d = clr_q + 1'b1;
				if (clr_q == LAST_BLK) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				// Take a command only once the result slot is free.
				if (cmd_valid && (!out_valid_q || !rsp_stall)) begin
					cmd_pop = 1'b1;
					op_d = cmd.op;
					start_d = cmd_blk;
					cur_d = cmd_blk;
					n_d = NW'(1);
					first_d = 1'b1;
					ra = cmd_blk;
					case (cmd.op)
						OP_ALLOC: begin
							scan_d = SW'(1);
							chk_d = 1'b0;
							state_d = S_SEARCH;
						end
						OP_EXTEND, OP_FREE, OP_LOCATE: state_d = S_WALK;
						OP_READ: state_d = S_READ;
						default: begin
							res_load = 1'b1;
							res.status = STAT_BAD;
						end
					endcase
				end
			end
			S_READ: begin
				res_load = 1'b1;
				if (rd_next) begin
					res.block_index = IDX_W'(rd_link);
				end else begin
					res.at_end = 1'b1;
				end
				state_d = S_IDLE;
			end
			S_WALK: begin
				first_d = 1'b0;
				if (first_q && !rd_busy) begin
					res_load = 1'b1;
					res.status = STAT_BAD;
					state_d = S_IDLE;
				end else if (rd_next) begin
					if (n_q >= N_MAX) begin
						res_load = 1'b1;
						res.status = STAT_LONG;
						state_d = S_IDLE;
					end else begin
						cur_d = rd_link;
						ra = rd_link;
						n_d = n_q + 1'b1;
					end
				end else begin
					// cur_q is the tail
					case (op_q)
						OP_LOCATE: begin
							res_load = 1'b1;
							res.block_index = IDX_W'(cur_q);
							res.chain_length = LEN_W'(n_q);
							state_d = S_IDLE;
						end
						OP_EXTEND: begin
							tail_busy_d = rd_busy;
							scan_d = SW'(1);
							chk_d = 1'b0;
							state_d = S_SEARCH;
						end
						default: begin
							cur_d = start_q;
							ra = start_q;
							state_d = S_FREE;
						end
					endcase
				end
			end
			S_SEARCH: begin
				// One read issued per cycle; rd_q holds the entry at chk_addr_q.
				if (issue) begin
					ra = scan_q[ABW-1:0];
					scan_d = scan_q + 1'b1;
				end
				chk_d = issue;
				chk_addr_d = scan_q[ABW-1:0];
				if (chk_q && !rd_busy) begin
					we = 1'b1;
					wa = chk_addr_q;
					wd = {1'b1, 1'b0, {ABW{1'b0}}};
					if (op_q == OP_EXTEND) begin
						fb_d = chk_addr_q;
						state_d = S_LINK;
					end else begin
						res_load = 1'b1;
						res.block_index = IDX_W'(chk_addr_q);
						res.chain_length = LEN_W'(1);
						state_d = S_IDLE;
					end
				end else if (!chk_q && !issue) begin
					res_load = 1'b1;
					res.status = STAT_NOFREE;
					if (op_q == OP_EXTEND) begin
						res.block_index = IDX_W'(cur_q);
						res.chain_length = LEN_W'(n_q);
					end
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				// Keep the tail's busy bit; a free tail taken as the new block stays unlinked.
				if (fb_q != cur_q) begin
					we = 1'b1;
					wa = cur_q;
					wd = {tail_busy_q, 1'b1, fb_q};
				end
				res_load = 1'b1;
				res.block_index = IDX_W'(fb_q);
				res.chain_length = LEN_W'(n_q + 1'b1);
				state_d = S_IDLE;
			end
			S_FREE: begin
				// Drop the current block and read its successor in the same cycle.
				we = 1'b1;
				wa = cur_q;
				wd = '0;
				if (rd_next) begin
					cur_d = rd_link;
					ra = rd_link;
				end else begin
					res_load = 1'b1;
					res.chain_length = LEN_W'(n_q);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			first_q <= 1'b0;
			chk_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			first_q <= first_d;
			chk_q <= chk_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		start_q <= start_d;
		cur_q <= cur_d;
		n_q <= n_d;
		scan_q <= scan_d;
		chk_addr_q <= chk_addr_d;
		fb_q <= fb_d;
		tail_busy_q <= tail_busy_d;
		if (res_load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fat_q[wa] <= wd;
		end
		rd_q <= fat_q[ra];
	end

endmodule

// File: sv/fat_chain_manager.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// File allocation table chain manager.
// Request channel: req_valid / req_stall with req (action, start_block);
// an item is taken at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with rsp (status, block_index,
// chain_length, at_end); exactly one response per request, in order.
// After reset the table is cleared one entry a cycle; req_stall stays high
// until the pass ends. The table sits in a single memory with one write and
// one registered read port, and every request but a bad one walks it one
// entry per cycle through that read port. A bad request needs no table read,
// read link reads one entry, locate walks the chain to its tail, allocate
// scans for a free block from block 1 up, extend walks to the tail and then
// scans, and free walks to the tail and then clears the chain from its start.
// A two-entry command queue lets requests be taken while one is at work.
// The response sits in an output register; while rsp_stall is high it holds,
// and the next request waits in the queue until the register frees.
module fat_chain_manager #(
	parameter int NUM_BLOCKS = fcm_pkg::FCM_NUM_BLOCKS
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input fcm_pkg::fcm_in_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output fcm_pkg::fcm_out_t rsp
);
	import fcm_pkg::*;

	logic q_push;
	logic q_full;
	logic q_valid;
	logic q_pop;
	fcm_cmd_t q_in;
	fcm_cmd_t q_head;
	fcm_eng_stat_t eng_stat;
	logic end_clean;

	fcm_front #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.clearing(eng_stat.clearing),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_in)
	);

	fcm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_in),
		.full(q_full),
		.valid(q_valid),
		.head(q_head),
		.pop(q_pop)
	);

	fcm_engine #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_valid),
		.cmd(q_head),
		.cmd_pop(q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.stat(eng_stat)
	);

	assign end_clean = (rsp.status == STAT_OK) && (rsp.block_index == '0);

	`FCM_ASSERT_IMP(a_push_not_full, q_push, !q_full, "command pushed into a full queue")
	`FCM_ASSERT_IMP(a_no_take_clear, eng_stat.clearing, !q_push, "request taken during clear")
	`FCM_ASSERT_IMP(a_done_slot_free, eng_stat.done, !rsp_valid || !rsp_stall, "result over held item")
	`FCM_ASSERT_NXT(a_done_shows, eng_stat.done, rsp_valid, "finished result not presented")
	`FCM_ASSERT_IMP(a_end_clean, rsp_valid && rsp.at_end, end_clean, "end of chain carries a link")

endmodule
